### design/lzss_pkg.sv
// Package for the LZ77 token encoder: payload structs, sizes, DEFLATE tables.
// Used by every module of the block.
`default_nettype none
package lzss_pkg;
  localparam int WindowSizeDefault    = 4096;
  localparam int LookaheadSizeDefault = 258;
  localparam int MinMatch             = 3;
  localparam int MaxMatch             = 258;
  localparam int LenSymbolBase        = 257;

  localparam logic CmdPush  = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       is_match;
    logic [7:0] literal;
    logic [8:0] match_length;
    logic [8:0] length_symbol;
    logic [4:0] length_extra;
    logic [4:0] distance_symbol;
    logic [9:0] distance_extra;
    logic       last_token;
  } out_item_t;

  // Work request from the front to the search engine.
  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } req_t;

  function automatic logic [8:0] len_base(input logic [4:0] i);
    logic [8:0] r;
    begin
      case (i)
        5'd0: r = 9'd3;    5'd1: r = 9'd4;    5'd2: r = 9'd5;    5'd3: r = 9'd6;
        5'd4: r = 9'd7;    5'd5: r = 9'd8;    5'd6: r = 9'd9;    5'd7: r = 9'd10;
        5'd8: r = 9'd11;   5'd9: r = 9'd13;   5'd10: r = 9'd15;  5'd11: r = 9'd17;
        5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;  5'd15: r = 9'd31;
        5'd16: r = 9'd35;  5'd17: r = 9'd43;  5'd18: r = 9'd51;  5'd19: r = 9'd59;
        5'd20: r = 9'd67;  5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
        5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195; 5'd27: r = 9'd227;
        default: r = 9'd258;
      endcase
      return r;
    end
  endfunction

  function automatic logic [15:0] dist_base(input logic [4:0] i);
    logic [15:0] r;
    begin
      case (i)
        5'd0: r = 16'd1;      5'd1: r = 16'd2;      5'd2: r = 16'd3;
        5'd3: r = 16'd4;      5'd4: r = 16'd5;      5'd5: r = 16'd7;
        5'd6: r = 16'd9;      5'd7: r = 16'd13;     5'd8: r = 16'd17;
        5'd9: r = 16'd25;     5'd10: r = 16'd33;    5'd11: r = 16'd49;
        5'd12: r = 16'd65;    5'd13: r = 16'd97;    5'd14: r = 16'd129;
        5'd15: r = 16'd193;   5'd16: r = 16'd257;   5'd17: r = 16'd385;
        5'd18: r = 16'd513;   5'd19: r = 16'd769;   5'd20: r = 16'd1025;
        5'd21: r = 16'd1537;  5'd22: r = 16'd2049;  5'd23: r = 16'd3073;
        5'd24: r = 16'd4097;  5'd25: r = 16'd6145;  5'd26: r = 16'd8193;
        5'd27: r = 16'd12289; 5'd28: r = 16'd16385;
        default: r = 16'd24577;
      endcase
      return r;
    end
  endfunction

  // Length symbol index: largest i with len_base(i) <= len.
  function automatic logic [4:0] len_index(input logic [8:0] len);
    logic [4:0] r;
    begin
      r = 5'd0;
      for (int i = 1; i < 29; i++) begin
        if (len_base(5'(i)) <= len) r = 5'(i);
      end
      return r;
    end
  endfunction

  function automatic logic [4:0] dist_index(input logic [15:0] d_val);
    logic [4:0] r;
    begin
      r = 5'd0;
      for (int i = 1; i < 30; i++) begin
        if (dist_base(5'(i)) <= d_val) r = 5'(i);
      end
      return r;
    end
  endfunction
endpackage
`default_nettype wire

### design/lzss_front.sv
// Front end: accepts items and queues them for the search engine.
// Depends on lzss_pkg.
`default_nettype none
module lzss_front
  import lzss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire logic     in_valid,
  output logic          in_stall,
  output req_t          req,
  output logic          req_valid,
  input  wire logic     req_take
);
  // Two-entry queue.
  req_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign pop       = req_valid && req_take;
  assign req_valid = (count != 2'd0);
  assign req       = q[rd_ptr];

  // Store and advance queue pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].command    <= in_item.command;
      q[wr_ptr].byte_value <= in_item.byte_value;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### design/lzss_engine.sv
// Back end: lookahead and window memories, sequential match search, coding.
// Depends on lzss_pkg.
`default_nettype none
module lzss_engine
  import lzss_pkg::*;
#(
  parameter int WINDOW_SIZE    = WindowSizeDefault,
  parameter int LOOKAHEAD_SIZE = LookaheadSizeDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_t      req,
  input  wire logic      req_valid,
  output logic           req_take,
  output out_item_t      result,
  output logic           result_valid,
  input  wire logic      result_stall
);
  localparam int WAW = $clog2(WINDOW_SIZE);
  localparam int WFW = $clog2(WINDOW_SIZE + 1);
  localparam int LAW = $clog2(LOOKAHEAD_SIZE);
  localparam int LFW = $clog2(LOOKAHEAD_SIZE + 1);
  localparam int DW  = WFW;

  typedef enum logic [3:0] {
    S_IDLE, S_DSTART, S_RD, S_CMP, S_DNEXT, S_CODE1, S_CODE2, S_CONS_RD, S_CONS_WR, S_OUT
  } state_t;

  state_t state;

  logic [7:0] win_mem [WINDOW_SIZE];
  logic [7:0] la_mem  [LOOKAHEAD_SIZE];
  logic [7:0] win_q, la_q;
  logic [WAW-1:0] win_raddr;
  logic [LAW-1:0] la_raddr, la_raddr2;
  logic [7:0] la_q2;

  logic [WAW-1:0] wptr;
  logic [WFW-1:0] wfill;
  logic [LAW-1:0] lhead;
  logic [LFW-1:0] lfill;

  logic [DW-1:0]  cand_dist, best_dist;
  logic [8:0]     k, maxlen, best_len, cons_left;
  logic           last_flag;
  logic [4:0]     lidx, didx;

  // Wrap helper.
  function automatic logic [LAW-1:0] la_add(input logic [LAW-1:0] a, input logic [9:0] b);
    logic [LAW+10:0] s;
    begin
      s = (LAW+11)'(a) + (LAW+11)'(b);
      if (s >= (LAW+11)'(LOOKAHEAD_SIZE)) s = s - (LAW+11)'(LOOKAHEAD_SIZE);
      return LAW'(s);
    end
  endfunction

  // Candidate byte k of distance cand_dist: window if k < cand_dist, else lookahead.
  logic cand_in_win;
  logic [DW+9:0] wsum;
  assign cand_in_win = ({{(DW > 9 ? DW-9 : 0){1'b0}}, k} < DW'(cand_dist)) || (DW < 9);
  assign wsum = (DW+10)'(wptr) + (DW+10)'(WINDOW_SIZE) - (DW+10)'(cand_dist) + (DW+10)'(k);
  assign win_raddr = (wsum >= (DW+10)'(WINDOW_SIZE)) ?
                     WAW'(wsum - (DW+10)'(WINDOW_SIZE)) : WAW'(wsum);
  assign la_raddr  = la_add(lhead, 10'(k - 9'(cand_dist)));
  assign la_raddr2 = la_add(lhead, 10'(k));
  logic use_win;

  // Memory reads registered; lookahead writes on push, window on consume.
  always_ff @(posedge clk) begin
    win_q <= win_mem[win_raddr];
    la_q  <= la_mem[cand_in_win ? la_raddr2 : la_raddr];
    la_q2 <= la_mem[la_raddr2];
    if (state == S_IDLE && req_valid && req.command == CmdPush &&
        lfill < LFW'(LOOKAHEAD_SIZE))
      la_mem[la_add(lhead, 10'(lfill))] <= req.byte_value;
    if (state == S_CONS_WR) win_mem[wptr] <= la_q2;
  end

  assign req_take = (state == S_IDLE);
  assign result_valid = (state == S_OUT);

  logic [8:0] lfill9;
  assign lfill9 = 9'(lfill);

  // Sequencer: one window distance per pass; each byte compare goes through S_RD and S_CMP.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr  <= '0;
      wfill <= '0;
      lhead <= '0;
      lfill <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.command == CmdPush) begin
              last_flag <= 1'b0;
              if (lfill < LFW'(LOOKAHEAD_SIZE)) begin
                lfill <= lfill + 1'b1;
                if (lfill + 1'b1 >= LFW'(LOOKAHEAD_SIZE)) state <= S_DSTART;
              end else state <= S_DSTART;
            end else if (lfill != '0) begin
              last_flag <= 1'b1;
              state     <= S_DSTART;
            end
          end
          maxlen   <= (lfill9 < 9'(MaxMatch)) ? lfill9 : 9'(MaxMatch);
          cand_dist <= DW'(1);
          best_len <= '0;
          best_dist <= '0;
          k        <= '0;
        end
        S_DSTART: begin
          maxlen <= (lfill9 < 9'(MaxMatch)) ? lfill9 : 9'(MaxMatch);
          k <= '0;
          state <= (DW'(cand_dist) <= DW'(wfill)) ? S_RD : S_CODE1;
        end
        S_RD: begin
          use_win <= cand_in_win;
          state <= (k < maxlen) ? S_CMP : S_DNEXT;
        end
        S_CMP: begin
          if ((use_win ? win_q : la_q) == la_q2) begin
            k <= k + 1'b1;
            state <= S_RD;
          end else state <= S_DNEXT;
        end
        S_DNEXT: begin
          if (k >= 9'(MinMatch) && k > best_len) begin
            best_len  <= k;
            best_dist <= cand_dist;
          end
          cand_dist <= cand_dist + 1'b1;
          k     <= '0;
          state <= S_DSTART;
        end
        S_CODE1: begin
          lidx <= len_index(best_len);
          didx <= dist_index(16'(best_dist));
          cons_left <= (best_len >= 9'(MinMatch)) ? best_len : 9'd1;
          k <= '0;
          result.is_match <= (best_len >= 9'(MinMatch));
          result.literal  <= (best_len >= 9'(MinMatch)) ? 8'd0 : la_q2;
          state <= S_CODE2;
        end
        S_CODE2: begin
          if (result.is_match) begin
            result.match_length    <= best_len;
            result.length_symbol   <= 9'(LenSymbolBase) + 9'(lidx);
            result.length_extra    <= 5'(best_len - len_base(lidx));
            result.distance_symbol <= didx;
            result.distance_extra  <= 10'(16'(best_dist) - dist_base(didx));
          end else begin
            result.match_length    <= '0;
            result.length_symbol   <= '0;
            result.length_extra    <= '0;
            result.distance_symbol <= '0;
            result.distance_extra  <= '0;
          end
          state <= S_CONS_RD;
        end
        S_CONS_RD: begin
          state <= S_CONS_WR;
        end
        S_CONS_WR: begin
          wptr  <= WAW'((WFW+1)'(wptr) + 1'b1 == (WFW+1)'(WINDOW_SIZE) ? 0 : wptr + 1'b1);
          if (wfill < WFW'(WINDOW_SIZE)) wfill <= wfill + 1'b1;
          lhead <= la_add(lhead, 10'd1);
          lfill <= lfill - 1'b1;
          cons_left <= cons_left - 1'b1;
          if (cons_left == 9'd1) begin
            result.last_token <= last_flag && (lfill == LFW'(1));
            state <= S_OUT;
          end else state <= S_CONS_RD;
        end
        S_OUT: begin
          if (!result_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/lzss_deflate_token_encoder.sv
// LZ77 token encoder with DEFLATE length/distance coding.
// Channels: in (command, byte_value) and out (one token struct), both
// valid/stall. A push adds a byte to the lookahead; once the lookahead is
// full a token is produced. A drain produces one token while data remains,
// with last_token set when the lookahead empties.
// Time per token grows with window fill: the search visits each window
// distance in turn (S_DSTART, then S_RD and S_CMP per compared byte, then
// S_DNEXT), coding runs in S_CODE1 and S_CODE2, and each consumed byte
// passes S_CONS_RD and S_CONS_WR before S_OUT. Items that produce no token
// are taken one per cycle while the engine is idle. A two-entry input queue
// lets the sender run ahead.
// Reset clears pointers and fill counts; memories are not cleared.
// When the receiver stalls, the token is held and the search engine waits;
// input is still taken until the queue fills.
// Depends on lzss_pkg, lzss_front, lzss_engine.
`default_nettype none
module lzss_deflate_token_encoder
  import lzss_pkg::*;
#(
  parameter int WINDOW_SIZE    = WindowSizeDefault,
  parameter int LOOKAHEAD_SIZE = LookaheadSizeDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_item,
  input  wire logic      in_valid,
  output logic           in_stall,
  output out_item_t      out_item,
  output logic           out_valid,
  input  wire logic      out_stall
);
  req_t req;
  logic req_valid, req_take;

  lzss_front u_front (
    .clk, .rst, .in_item, .in_valid, .in_stall,
    .req, .req_valid, .req_take
  );

  lzss_engine #(
    .WINDOW_SIZE(WINDOW_SIZE), .LOOKAHEAD_SIZE(LOOKAHEAD_SIZE)
  ) u_engine (
    .clk, .rst, .req, .req_valid, .req_take,
    .result(out_item), .result_valid(out_valid), .result_stall(out_stall)
  );
endmodule
`default_nettype wire
